### sv/kernel_table_interpolator_macros.svh
// assertion macros for the kernel table interpolator
`ifndef KERNEL_TABLE_INTERPOLATOR_MACROS_SVH
`define KERNEL_TABLE_INTERPOLATOR_MACROS_SVH
// property that must hold on every edge out of reset
`define KTI_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);
// implication whose consequent is checked in the next cycle
`define KTI_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error(msg);
`endif

### sv/kti_pkg.sv
// shared types and constants for the kernel table interpolator
`timescale 1ns / 1ps
package kti_pkg;
    localparam int TABLE_DEPTH_DEF = 1024;
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;
    localparam logic [0:0] REG_TABLE_COUNT = 1'd0;
    localparam logic [0:0] REG_ETA_SCALE   = 1'd1;
    localparam logic [10:0] TABLE_COUNT_RST = 11'd2;
    localparam logic [31:0] ETA_SCALE_RST   = 32'd65536;

    typedef struct packed {
        logic [31:0] kernel_value;
        logic        beyond_table;
    } t_result;
endpackage

### sv/kti_if.sv
// valid/ready channel interfaces for items, results and config writes
`timescale 1ns / 1ps
interface kti_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [9:0]  entry_index;
    logic [23:0] entry_eta;
    logic signed [31:0] entry_weight;
    logic [31:0] g_squared;
    modport source (output valid, cmd, entry_index, entry_eta, entry_weight, g_squared,
                    input ready);
    modport sink   (input valid, cmd, entry_index, entry_eta, entry_weight, g_squared,
                    output ready);
endinterface

interface kti_out_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] kernel_value;
    logic        beyond_table;
    modport source (output valid, kernel_value, beyond_table, input ready);
    modport sink   (input valid, kernel_value, beyond_table, output ready);
endinterface

interface kti_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### sv/kti_ram.sv
// generic single-port-write, single-read ram with registered read
`timescale 1ns / 1ps
module kti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### sv/kti_front.sv
// front end: accepts items, writes loads, computes eta for queries into a queue
`timescale 1ns / 1ps
module kti_front #(
    parameter int TABLE_DEPTH = 1024,
    parameter int QDEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    kti_in_if.sink      in_ch,
    input  logic [31:0] i_eta_scale,
    output logic        o_we,
    output logic [$clog2(TABLE_DEPTH)-1:0] o_waddr,
    output logic [23:0] o_weta,
    output logic [31:0] o_wweight,
    output logic        o_qvalid,
    output logic [39:0] o_qeta,
    input  logic        i_qpop,
    input  logic        i_back_busy
);
    import kti_pkg::*;
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int QW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001, S_SQRT = 3'b010, S_MUL = 3'b100
    } t_fstate;

    t_fstate     r_st;
    logic [47:0] r_rem;
    logic [47:0] r_val;
    logic [23:0] r_root;
    logic [4:0]  r_cnt;
    logic [39:0] r_eta [QDEPTH];
    logic [QW-1:0] r_wp, r_rp;
    logic [QW:0] r_fill;

    logic acc, push;
    logic [49:0] trial;
    logic [25:0] tsub;
    logic [55:0] prod;

    // a load waits until no query is in flight so it cannot overtake one
    assign in_ch.ready = (r_st == S_IDLE) && (r_fill != (QW+1)'(QDEPTH)) &&
                         ((in_ch.cmd == CMD_QUERY) || ((r_fill == '0) && !i_back_busy));
    assign acc = in_ch.valid && in_ch.ready;
    // load indexes past the depth are dropped
    assign o_we = acc && (in_ch.cmd == CMD_LOAD) &&
                  ({22'd0, in_ch.entry_index} < 32'(TABLE_DEPTH));
    assign o_waddr = AW'(in_ch.entry_index);
    assign o_weta = in_ch.entry_eta;
    assign o_wweight = in_ch.entry_weight;

    // restoring square root, one result bit per cycle, 24 bits of root
    assign trial = {r_rem[47:0], r_val[47:46]};
    assign tsub = {r_root, 2'b01};
    assign prod = r_root * i_eta_scale;
    assign push = (r_st == S_MUL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_wp <= '0;
            r_rp <= '0;
            r_fill <= '0;
        end else begin
            case (r_st)
                S_IDLE: if (acc && in_ch.cmd == CMD_QUERY) begin
                    r_val <= {in_ch.g_squared, 16'd0};
                    r_rem <= '0;
                    r_root <= '0;
                    r_cnt <= 5'd0;
                    r_st <= S_SQRT;
                end
                S_SQRT: begin
                    if (trial >= {24'd0, tsub}) begin
                        r_rem <= 48'(trial - {24'd0, tsub});
                        r_root <= {r_root[22:0], 1'b1};
                    end else begin
                        r_rem <= trial[47:0];
                        r_root <= {r_root[22:0], 1'b0};
                    end
                    r_val <= {r_val[45:0], 2'b00};
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd23) r_st <= S_MUL;
                end
                S_MUL: begin
                    r_eta[r_wp] <= prod[55:16];
                    r_wp <= (r_wp == QW'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
            if (i_qpop) r_rp <= (r_rp == QW'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            r_fill <= r_fill + (push ? 1'b1 : 1'b0) - (i_qpop ? 1'b1 : 1'b0);
        end
    end

    assign o_qvalid = (r_fill != '0);
    assign o_qeta = r_eta[r_rp];
endmodule

### sv/kti_back.sv
// back end: binary search, segment reads and interpolation divide
`timescale 1ns / 1ps
module kti_back #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [10:0] i_table_count,
    input  logic        i_qvalid,
    input  logic [39:0] i_qeta,
    output logic        o_qpop,
    output logic [$clog2(TABLE_DEPTH)-1:0] o_raddr,
    input  logic [23:0] i_reta,
    input  logic [31:0] i_rweight,
    output logic        o_busy,
    kti_out_if.source   out_ch
);
    import kti_pkg::*;
    `include "kernel_table_interpolator_macros.svh"
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = AW + 1;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001, S_RD0 = 10'b0000000010, S_RDN = 10'b0000000100,
        S_SRCH  = 10'b0000001000, S_SWT = 10'b0000010000, S_RLO = 10'b0000100000,
        S_RHI   = 10'b0001000000, S_MUL = 10'b0010000000, S_DIV = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_bstate;

    t_bstate r_st;
    logic [39:0] r_eta;
    logic [CW-1:0] r_n, r_lo, r_hi, r_mid;
    logic [23:0] r_alo;
    logic signed [31:0] r_wlo;
    logic [7:0] r_pend;
    logic [63:0] r_num;
    logic [63:0] r_quo;
    logic [64:0] r_rem;
    logic [23:0] r_den;
    logic        r_neg;
    logic [6:0]  r_cnt;
    logic        r_ovalid;
    logic signed [31:0] r_kv;
    logic        r_bt;

    logic [CW-1:0] ncl, mid;
    logic signed [32:0] dw;
    logic [24:0] tt;
    logic signed [58:0] mprod;
    logic [64:0] rsh;
    logic [63:0] qsig;

    always_comb begin
        if (i_table_count < 11'd2) ncl = CW'(2);
        else if ({21'd0, i_table_count} > 32'(TABLE_DEPTH)) ncl = CW'(TABLE_DEPTH);
        else ncl = CW'(i_table_count);
    end
    assign mid = CW'(({1'b0, r_lo} + {1'b0, r_hi}) >> 1);
    assign dw = 33'(signed'(i_rweight)) - 33'(r_wlo);
    assign tt = 25'(r_eta) - {1'b0, r_alo};
    assign mprod = dw * signed'({1'b0, tt});
    assign rsh = {r_rem[63:0], r_num[63]};
    assign qsig = r_neg ? 64'(-r_quo) : r_quo;

    always_comb begin
        case (r_st)
            S_RD0:  o_raddr = '0;
            S_RDN:  o_raddr = AW'(r_n - 1'b1);
            S_SRCH: o_raddr = AW'(mid);
            S_RLO:  o_raddr = AW'(r_lo);
            S_RHI:  o_raddr = AW'(r_hi);
            default: o_raddr = AW'(r_mid);
        endcase
    end

    assign o_qpop = (r_st == S_IDLE) && i_qvalid && !r_ovalid;
    assign o_busy = (r_st != S_IDLE);
    assign out_ch.valid = r_ovalid;
    assign out_ch.kernel_value = r_kv;
    assign out_ch.beyond_table = r_bt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && out_ch.ready) r_ovalid <= 1'b0;
            case (r_st)
                S_IDLE: if (o_qpop) begin
                    r_eta <= i_qeta;
                    r_n <= ncl;
                    r_st <= S_RD0;
                end
                S_RD0: r_st <= S_RDN;
                S_RDN: begin
                    // first entry data arrives here
                    if (r_eta <= {16'd0, i_reta}) begin
                        r_kv <= i_rweight;
                        r_bt <= 1'b0;
                        r_st <= S_OUT;
                    end else begin
                        r_lo <= '0;
                        r_hi <= r_n - 1'b1;
                        r_st <= S_SWT;
                        r_pend <= 8'd1;
                    end
                end
                S_SWT: begin
                    if (r_pend == 8'd1) begin
                        // last entry read returns
                        r_pend <= 8'd0;
                        if (r_eta > {16'd0, i_reta}) begin
                            r_kv <= i_rweight;
                            r_bt <= 1'b1;
                            r_st <= S_OUT;
                        end else if (r_lo + 1'b1 < r_hi) begin
                            r_mid <= mid;
                            r_st <= S_SRCH;
                        end else r_st <= S_RLO;
                    end else begin
                        if (r_eta > {16'd0, i_reta}) r_lo <= r_mid;
                        else r_hi <= r_mid;
                        r_st <= S_SRCH;
                    end
                end
                S_SRCH: begin
                    if (r_lo + 1'b1 < r_hi) begin
                        r_mid <= mid;
                        r_pend <= 8'd2;
                        r_st <= S_SWT;
                    end else r_st <= S_RLO;
                end
                S_RLO: r_st <= S_RHI;
                S_RHI: begin
                    r_alo <= i_reta;
                    r_wlo <= i_rweight;
                    r_st <= S_MUL;
                end
                S_MUL: begin
                    r_neg <= mprod[58];
                    r_num <= mprod[58] ? 64'(-mprod) : 64'(mprod);
                    r_den <= i_reta - r_alo;
                    r_rem <= '0;
                    r_quo <= '0;
                    r_cnt <= 7'd0;
                    r_st <= S_DIV;
                end
                S_DIV: begin
                    if (rsh >= {41'd0, r_den}) begin
                        r_rem <= rsh - {41'd0, r_den};
                        r_quo <= {r_quo[62:0], 1'b1};
                    end else begin
                        r_rem <= rsh;
                        r_quo <= {r_quo[62:0], 1'b0};
                    end
                    r_num <= {r_num[62:0], 1'b0};
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt == 7'd63) r_st <= S_OUT;
                end
                S_OUT: if (!r_ovalid) begin
                    if (r_pend == 8'd3) begin
                        r_kv <= 32'(r_wlo + qsig[31:0]);
                        r_bt <= 1'b0;
                    end
                    r_pend <= 8'd0;
                    r_ovalid <= 1'b1;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
            if (r_st == S_DIV && r_cnt == 7'd63) r_pend <= 8'd3;
        end
    end

    `KTI_ASSERT(a_pop_idle, !(o_qpop && r_ovalid), "queue pop while result pending")
    `KTI_ASSERT_NEXT(a_out_hold, r_ovalid && !out_ch.ready, r_ovalid && $stable(r_kv),
        "result dropped while stalled")
    `KTI_ASSERT(a_seg_order, !(r_st == S_SRCH) || (r_lo < r_hi), "search bounds crossed")
endmodule

### sv/kernel_table_interpolator.sv
// Kernel table interpolator top level. A load word writes one (eta, weight) table
// entry, but is held off until no query is in flight. A query word passes through
// 24 square root steps and a scale multiply in the front after acceptance. The back
// end then works through the binary search probes, four ram reads and a 64-step
// bit-serial interpolation divider for an interpolated query; a query whose eta is
// at or below the first entry or beyond the last skips the search and the divider.
// A two-entry eta queue lets front and back overlap, so back-to-back queries are
// bound by the back end. Table contents are undefined until loaded and need no
// clearing pass.
`timescale 1ns / 1ps
module kernel_table_interpolator #(
    parameter int TABLE_DEPTH = kti_pkg::TABLE_DEPTH_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    kti_in_if.sink   in_ch,
    kti_out_if.source out_ch,
    kti_cfg_if.sink  cfg_ch
);
    import kti_pkg::*;
    localparam int AW = $clog2(TABLE_DEPTH);

    logic [10:0] r_table_count;
    logic [31:0] r_eta_scale;
    logic we, qvalid, qpop, back_busy;
    logic [AW-1:0] waddr, raddr;
    logic [23:0] weta, reta;
    logic [31:0] wweight, rweight;
    logic [39:0] qeta;

    assign cfg_ch.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_count <= TABLE_COUNT_RST;
            r_eta_scale <= ETA_SCALE_RST;
        end else if (cfg_ch.valid) begin
            if (cfg_ch.index == 8'(REG_TABLE_COUNT)) r_table_count <= cfg_ch.data[10:0];
            else if (cfg_ch.index == 8'(REG_ETA_SCALE)) r_eta_scale <= cfg_ch.data;
        end
    end

    kti_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
        .i_clk, .i_rst_n, .in_ch, .i_eta_scale(r_eta_scale),
        .o_we(we), .o_waddr(waddr), .o_weta(weta), .o_wweight(wweight),
        .o_qvalid(qvalid), .o_qeta(qeta), .i_qpop(qpop), .i_back_busy(back_busy)
    );

    kti_ram #(.WIDTH(24), .DEPTH(TABLE_DEPTH)) u_eta_ram (
        .i_clk, .i_we(we), .i_waddr(waddr), .i_wdata(weta),
        .i_raddr(raddr), .o_rdata(reta)
    );
    kti_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_wt_ram (
        .i_clk, .i_we(we), .i_waddr(waddr), .i_wdata(wweight),
        .i_raddr(raddr), .o_rdata(rweight)
    );

    kti_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
        .i_clk, .i_rst_n, .i_table_count(r_table_count),
        .i_qvalid(qvalid), .i_qeta(qeta), .o_qpop(qpop), .o_raddr(raddr),
        .i_reta(reta), .i_rweight(rweight), .o_busy(back_busy), .out_ch
    );
endmodule
